@@ src/cprt_pkg.sv @@
package cprt_pkg;

	localparam int TABLE_DEPTH       = 32;
	localparam int MAX_PREFIX_DIGITS = 12;
	localparam int CARD_DIGITS       = 12;

	localparam int DIG_W   = 4;
	localparam int VALUE_W = 40;
	localparam int ENT_W   = DIG_W + VALUE_W;
	localparam int CARD_W  = 4 * CARD_DIGITS;
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PFX_N   = CARD_DIGITS + 1;
	localparam int PFX_AW  = $clog2(PFX_N);
	localparam int POW_W   = 50;

	typedef enum logic [1:0] {
		FN_CLEAR  = 2'd0,
		FN_APPEND = 2'd1,
		FN_LOOKUP = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		STS_NOT_FOUND = 3'd0,
		STS_FOUND     = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_APPENDED  = 3'd3,
		STS_FULL      = 3'd4,
		STS_BAD_ENTRY = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_DONE
	} state_t;

	function automatic logic [POW_W-1:0] pow10(input logic [DIG_W-1:0] d);
		logic [POW_W-1:0] p;
		case (d)
			4'd0:    p = 50'd1;
			4'd1:    p = 50'd10;
			4'd2:    p = 50'd100;
			4'd3:    p = 50'd1000;
			4'd4:    p = 50'd10000;
			4'd5:    p = 50'd100000;
			4'd6:    p = 50'd1000000;
			4'd7:    p = 50'd10000000;
			4'd8:    p = 50'd100000000;
			4'd9:    p = 50'd1000000000;
			4'd10:   p = 50'd10000000000;
			4'd11:   p = 50'd100000000000;
			4'd12:   p = 50'd1000000000000;
			4'd13:   p = 50'd10000000000000;
			4'd14:   p = 50'd100000000000000;
			default: p = 50'd1000000000000000;
		endcase
		return p;
	endfunction

	function automatic logic bound_ok(input logic [DIG_W-1:0] d, input logic [VALUE_W-1:0] v);
		logic ok;
		if (d == '0 || 32'(d) > MAX_PREFIX_DIGITS) begin
			ok = 1'b0;
		end else begin
			ok = POW_W'(v) < pow10(d);
		end
		return ok;
	endfunction

	// prefix length is capped by the card digits held in the scratch table
	function automatic logic [PFX_AW-1:0] clip_digits(input logic [DIG_W-1:0] d);
		logic [PFX_AW-1:0] a;
		if (32'(d) > CARD_DIGITS) begin
			a = PFX_AW'(CARD_DIGITS);
		end else begin
			a = PFX_AW'(d);
		end
		return a;
	endfunction

endpackage

@@ src/card_prefix_range_table.sv @@
// Card prefix range table.
// Input channel (in_valid/in_ready) carries one command item: clear, append
// a low/high bound pair, or look up a BCD card number. Output channel
// (out_valid/out_ready) returns one status item per command, in order.
// Clear, append and lookup on an empty table finish in the accept cycle; the
// status is visible on the next cycle.
// A lookup first builds the card's decimal prefixes, one digit per cycle
// (one write into the 13-entry scratch table each), then walks the bound
// memories one entry per cycle through a read pipeline (bound read, prefix
// read, compare). It stops at the first match. One item is in work at a time.
// Reset clears the entry count and the output valid; the bound memories are
// not cleared and only entries below the count are ever read.
// A finished status sits in the output register until taken; a new clear or
// append is accepted in the same cycle the pending status is taken, and a
// finished lookup waits in its last state while the receiver stalls.
module card_prefix_range_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       func,
	input  logic [cprt_pkg::DIG_W-1:0]       low_digits,
	input  logic [cprt_pkg::VALUE_W-1:0]     low_value,
	input  logic [cprt_pkg::DIG_W-1:0]       high_digits,
	input  logic [cprt_pkg::VALUE_W-1:0]     high_value,
	input  logic [cprt_pkg::CARD_W-1:0]      card_bcd,
	input  logic [cprt_pkg::DIG_W-1:0]       card_digits,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       status
);
	import cprt_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]   count_q;
	logic               out_valid_q;
	status_t            status_q;

	logic               slot_free, in_fire, append_ok, start_lookup, do_append;
	logic               out_load, done_load;
	status_t            imm_status, load_status;

	// prefix build
	logic [PFX_AW-1:0]  k_q;
	logic               stop_q;
	logic [CARD_W-1:0]  card_q;
	logic [PFX_AW-1:0]  cd_lim_q;
	logic [VALUE_W-1:0] v_q;
	logic [3:0]         nib;
	logic [VALUE_W+3:0] mul10;
	logic               take_digit, prep_last;

	// scan pipeline
	logic [CNT_W-1:0]   scan_idx_q;
	logic               issue, v_s1_q, v_s2_q, match_s2, scan_end, found_q;
	logic [ENT_W-1:0]   low_rd_q, high_rd_q;
	logic [VALUE_W-1:0] lo_val_s2, hi_val_s2;
	logic [VALUE_W-1:0] pfx_lo_rd_q, pfx_hi_rd_q;

	logic [ENT_W-1:0]   low_mem  [TABLE_DEPTH];
	logic [ENT_W-1:0]   high_mem [TABLE_DEPTH];
	logic [VALUE_W-1:0] pfx_mem  [PFX_N];

	assign slot_free = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign append_ok = (32'(count_q) < TABLE_DEPTH) && bound_ok(low_digits, low_value) &&
		bound_ok(high_digits, high_value);

	always_comb begin
		unique case (func)
			FN_CLEAR:  imm_status = STS_EMPTY;
			FN_APPEND: begin
				if (32'(count_q) >= TABLE_DEPTH) begin
					imm_status = STS_FULL;
				end else if (!append_ok) begin
					imm_status = STS_BAD_ENTRY;
				end else begin
					imm_status = STS_APPENDED;
				end
			end
			FN_LOOKUP: imm_status = (count_q == '0) ? STS_EMPTY : STS_NOT_FOUND;
			default:   imm_status = STS_NOT_FOUND;
		endcase
	end

	assign start_lookup = in_fire && (func == FN_LOOKUP) && (count_q != '0);
	assign do_append    = in_fire && (func == FN_APPEND) && append_ok;

	assign nib        = card_q[CARD_W-1 -: 4];
	assign take_digit = !stop_q && (k_q < cd_lim_q) && (nib <= 4'd9);
	assign mul10      = {v_q, 3'b000} + {2'b00, v_q, 1'b0} + {{VALUE_W{1'b0}}, nib};
	assign prep_last  = (32'(k_q) == CARD_DIGITS);

	assign match_s2 = v_s2_q && (pfx_lo_rd_q >= lo_val_s2) && (pfx_hi_rd_q <= hi_val_s2);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start_lookup) state_d = S_PREP;
			S_PREP: if (prep_last) state_d = S_SCAN;
			S_SCAN: if (scan_end) state_d = S_DONE;
			S_DONE: if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		issue     = 1'b0;
		scan_end  = 1'b0;
		done_load = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = slot_free;
			S_PREP: ;
			S_SCAN: begin
				issue    = (scan_idx_q != count_q) && !match_s2;
				scan_end = match_s2 || ((scan_idx_q == count_q) && !v_s1_q && !v_s2_q);
			end
			S_DONE: done_load = slot_free;
			default: ;
		endcase
	end

	assign out_load    = (in_fire && !start_lookup) || done_load;
	assign load_status = done_load ? (found_q ? STS_FOUND : STS_NOT_FOUND) : imm_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STS_NOT_FOUND;
			k_q         <= '0;
			stop_q      <= 1'b0;
			scan_idx_q  <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && func == FN_CLEAR) begin
				count_q <= '0;
			end else if (do_append) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				status_q    <= load_status;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (start_lookup) begin
				k_q        <= '0;
				stop_q     <= 1'b0;
				scan_idx_q <= '0;
			end else if (state_q == S_PREP) begin
				if (!prep_last) k_q <= k_q + 1'b1;
				if (!take_digit) stop_q <= 1'b1;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			v_s1_q <= issue;
			v_s2_q <= v_s1_q && !match_s2;
			if (scan_end) found_q <= match_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start_lookup) begin
			card_q   <= card_bcd;
			cd_lim_q <= clip_digits(card_digits);
			v_q      <= '0;
		end else if (state_q == S_PREP) begin
			card_q <= {card_q[CARD_W-5:0], 4'h0};
			if (take_digit) v_q <= mul10[VALUE_W-1:0];
		end
		lo_val_s2 <= low_rd_q[VALUE_W-1:0];
		hi_val_s2 <= high_rd_q[VALUE_W-1:0];
	end

	// bound memories
	always_ff @(posedge clk) begin
		if (do_append) begin
			low_mem[count_q[ADDR_W-1:0]]  <= {low_digits, low_value};
			high_mem[count_q[ADDR_W-1:0]] <= {high_digits, high_value};
		end
		low_rd_q  <= low_mem[scan_idx_q[ADDR_W-1:0]];
		high_rd_q <= high_mem[scan_idx_q[ADDR_W-1:0]];
	end

	// card prefix scratch: entry k holds the value of the first k usable digits
	always_ff @(posedge clk) begin
		if (state_q == S_PREP) begin
			pfx_mem[k_q] <= v_q;
		end
		pfx_lo_rd_q <= pfx_mem[clip_digits(low_rd_q[ENT_W-1 -: DIG_W])];
		pfx_hi_rd_q <= pfx_mem[clip_digits(high_rd_q[ENT_W-1 -: DIG_W])];
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= TABLE_DEPTH)
		else $error("entry count above table depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && func == FN_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the table");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (count_q != '0))
		else $error("scan with empty table");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q || v_s2_q) |-> (state_q == S_SCAN))
		else $error("scan pipeline busy outside scan");

endmodule
